@@ hw/rtl/cjd_pkg.sv @@
// shared constants and event codes for the coalescing job dispatcher
package cjd_pkg;

  localparam int NUM_IDS = 64;
  localparam int IdW     = 6;
  localparam int KindW   = 3;
  localparam int IdxW    = $clog2(NUM_IDS);
  localparam int CntW    = $clog2(NUM_IDS + 1);

  typedef enum logic [KindW-1:0] {
    EV_START    = 3'd0,
    EV_STOP     = 3'd1,
    EV_ENQUEUE  = 3'd2,
    EV_TAKE     = 3'd3,
    EV_COMPLETE = 3'd4
  } event_kind_t;

endpackage

@@ hw/rtl/coalescing_job_dispatcher_unit.sv @@
// top level of the coalescing job dispatcher: bit tables, ready fifo and counters
//
// Usage: one event word per handshake on the input channel (kind, slot_id),
// one status word per event on the output channel. A word is taken at a rising
// edge with valid high and stall low; the receiver drives stall.
// Events: start, stop, enqueue, take next, complete. An enqueue of an id that
// is in flight only marks it pending; a completion re-queues a pending id once.
// Path: the update logic sits between the input register and the result
// register; an event word moves on once the result register is free or taken.
// Throughput: one event per cycle unless the output stalls. The in-flight and
// pending tables are flip-flop vectors and the ready fifo is a 64-entry memory
// with a prefetched head word register, so every event needs one state update.
// Reset (rst, synchronous): both tables, fifo pointers, the busy count and the
// run and drain flags are cleared; no clearing pass is needed and events are
// accepted as soon as rst is low.
// Output stall: the result word holds; the input register still takes one more
// word, after which in_stall rises until the result word is taken.
module coalescing_job_dispatcher_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [cjd_pkg::KindW-1:0] kind,
  input  logic [cjd_pkg::IdW-1:0]   slot_id,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     accepted,
  output logic                     take_valid,
  output logic [cjd_pkg::IdW-1:0]   take_id,
  output logic                     id_in_flight,
  output logic [cjd_pkg::CntW-1:0]  busy_count,
  output logic                     idle,
  output logic                     is_running,
  output logic                     draining
);
  import cjd_pkg::*;

  // input register
  logic              s1_valid;
  logic [KindW-1:0]  s1_kind;
  logic [IdW-1:0]    s1_id;
  logic              s1_go;

  // dispatcher state
  logic [NUM_IDS-1:0] inflight_bits, inflight_bits_next;
  logic [NUM_IDS-1:0] pending_bits, pending_bits_next;
  logic [IdxW-1:0]    fifo_head, fifo_head_next;
  logic [CntW-1:0]    fifo_fill, fifo_fill_next;
  logic [CntW-1:0]    inflight_total, inflight_total_next;
  logic               run_flag, run_flag_next;
  logic               stop_flag, stop_flag_next;

  // ready fifo memory and its prefetched head word
  logic [IdW-1:0]  ready_fifo [NUM_IDS];
  logic [IdW-1:0]  rd_data;
  logic            byp_hit;
  logic [IdW-1:0]  byp_data;
  logic [IdxW-1:0] rd_addr;
  logic [IdW-1:0]  fifo_top;

  // update logic signals
  logic              id_ok;
  logic [IdxW-1:0]   slot_idx;
  logic              push_req;
  logic              push_do;
  logic [IdxW:0]     push_sum;
  logic [IdxW-1:0]   push_pos;
  logic              acc_c;
  logic              take_c;
  logic [IdW-1:0]    take_id_c;
  logic              drain_end;

  // handshakes
  assign s1_go    = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind <= kind;
      s1_id   <= slot_id;
    end
  end

  // decode helpers
  assign id_ok    = 32'(s1_id) < NUM_IDS;
  assign slot_idx = IdxW'(s1_id);
  assign fifo_top = byp_hit ? byp_data : rd_data;

  // push position wraps round the ring
  always_comb begin
    push_sum = (IdxW+1)'(fifo_head) + (IdxW+1)'(fifo_fill);
    if (32'(push_sum) >= NUM_IDS) begin
      push_sum = push_sum - (IdxW+1)'(NUM_IDS);
    end
    push_pos = push_sum[IdxW-1:0];
  end

  // event processing
  always_comb begin
    inflight_bits_next  = inflight_bits;
    pending_bits_next   = pending_bits;
    fifo_head_next      = fifo_head;
    fifo_fill_next      = fifo_fill;
    inflight_total_next = inflight_total;
    run_flag_next       = run_flag;
    stop_flag_next      = stop_flag;
    push_req            = 1'b0;
    acc_c               = 1'b0;
    take_c              = 1'b0;
    take_id_c           = '0;
    drain_end           = 1'b0;

    unique case (s1_kind)
      EV_START: begin
        if (!run_flag) begin
          stop_flag_next = 1'b0;
          run_flag_next  = 1'b1;
        end
      end
      EV_STOP: begin
        if (run_flag || stop_flag) begin
          stop_flag_next    = 1'b1;
          run_flag_next     = 1'b0;
          pending_bits_next = '0;
        end
      end
      EV_ENQUEUE: begin
        if (run_flag && !stop_flag && id_ok) begin
          acc_c = 1'b1;
          if (inflight_bits[slot_idx]) begin
            pending_bits_next[slot_idx] = 1'b1;
          end else if (!pending_bits[slot_idx]) begin
            inflight_bits_next[slot_idx] = 1'b1;
            if (32'(inflight_total) < NUM_IDS) begin
              inflight_total_next = inflight_total + CntW'(1);
            end
            push_req = 1'b1;
          end
        end
      end
      EV_TAKE: begin
        if (fifo_fill != '0) begin
          take_c         = 1'b1;
          take_id_c      = fifo_top;
          fifo_head_next = (32'(fifo_head) == NUM_IDS - 1) ? '0 : fifo_head + IdxW'(1);
          fifo_fill_next = fifo_fill - CntW'(1);
        end
      end
      EV_COMPLETE: begin
        if (id_ok) begin
          pending_bits_next[slot_idx] = 1'b0;
          if (pending_bits[slot_idx] && run_flag && !stop_flag) begin
            push_req = 1'b1;
          end else begin
            inflight_bits_next[slot_idx] = 1'b0;
            if (inflight_total != '0) begin
              inflight_total_next = inflight_total - CntW'(1);
            end
          end
        end
      end
      default: begin
      end
    endcase

    // push is dropped when the fifo is full
    push_do = push_req && (32'(fifo_fill) < NUM_IDS);
    if (push_do) begin
      fifo_fill_next = fifo_fill + CntW'(1);
    end

    // end of drain clears both tables
    if (stop_flag_next && inflight_total_next == '0 && fifo_fill_next == '0) begin
      drain_end          = 1'b1;
      stop_flag_next     = 1'b0;
      inflight_bits_next = '0;
      pending_bits_next  = '0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight_bits  <= '0;
      pending_bits   <= '0;
      fifo_head      <= '0;
      fifo_fill      <= '0;
      inflight_total <= '0;
      run_flag       <= 1'b0;
      stop_flag      <= 1'b0;
    end else if (s1_go) begin
      inflight_bits  <= inflight_bits_next;
      pending_bits   <= pending_bits_next;
      fifo_head      <= fifo_head_next;
      fifo_fill      <= fifo_fill_next;
      inflight_total <= inflight_total_next;
      run_flag       <= run_flag_next;
      stop_flag      <= stop_flag_next;
    end
  end

  // fifo memory: write on push, prefetch the next head word into a register
  assign rd_addr = s1_go ? fifo_head_next : fifo_head;

  always_ff @(posedge clk) begin
    if (s1_go && push_do) begin
      ready_fifo[push_pos] <= s1_id;
    end
    rd_data <= ready_fifo[rd_addr];
  end

  // write-to-read bypass for a push landing on the head slot
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= s1_go && push_do && (push_pos == rd_addr);
    end
    byp_data <= s1_id;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      accepted     <= acc_c;
      take_valid   <= take_c;
      take_id      <= take_id_c;
      id_in_flight <= id_ok && inflight_bits_next[slot_idx];
      busy_count   <= inflight_total_next;
      idle         <= (inflight_total_next == '0) && (fifo_fill_next == '0) &&
                      !(|inflight_bits_next) && !(|pending_bits_next);
      is_running   <= run_flag_next;
      draining     <= stop_flag_next && !drain_end;
    end
  end

endmodule

@@ hw/rtl/cjd_checker.sv @@
// port-level checker for the coalescing job dispatcher, bound to the top level
module cjd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      accepted,
  input logic                      take_valid,
  input logic [cjd_pkg::IdW-1:0]   take_id,
  input logic [cjd_pkg::CntW-1:0]  busy_count,
  input logic                      idle,
  input logic                      is_running,
  input logic                      draining
);
  import cjd_pkg::*;

  // a stalled result word holds its status
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(busy_count) && $stable(is_running))
    else $error("result word changed while stalled");

  // running and draining never show together
  a_run_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_running && draining))
    else $error("running and draining both set");

  // an accepted enqueue leaves the dispatcher running with work outstanding
  a_acc_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> is_running && !idle)
    else $error("accepted enqueue without running or busy state");

  // idle means nothing in flight and no drain in progress
  a_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && idle |-> busy_count == '0 && !draining)
    else $error("idle with work outstanding");

  // a word without a taken id reports id zero
  a_take_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && !take_valid |-> take_id == '0)
    else $error("take id set without a taken word");

endmodule

bind coalescing_job_dispatcher_unit cjd_checker u_cjd_checker (.*);

@@ tb/tb_coalescing_job_dispatcher_unit.sv @@
// testbench for the coalescing job dispatcher: event stimulus, status prediction and checking
`timescale 1ns / 100ps

module tb_coalescing_job_dispatcher_unit;
  import cjd_pkg::*;

  // event codes outside the defined set, which the block must ignore
  localparam logic [KindW-1:0] EV_SPARE_LO  = 3'd5;
  localparam logic [KindW-1:0] EV_SPARE_MID = 3'd6;
  localparam logic [KindW-1:0] EV_SPARE_HI  = 3'd7;
  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = 8;
  localparam int DUE_DEPTH   = 8;

  // one status word as the block reports it
  typedef struct packed {
    logic            accepted;
    logic            take_valid;
    logic [IdW-1:0]  take_id;
    logic            id_in_flight;
    logic [CntW-1:0] busy_count;
    logic            idle;
    logic            is_running;
    logic            draining;
  } dispatch_status_t;

  // dispatcher state mirror and store of status words still due
  class dispatch_scoreboard;
    bit               inflight [NUM_IDS];
    bit               pend [NUM_IDS];
    logic [IdW-1:0]   ready_ids [NUM_IDS];
    int               head;
    int               fill;
    int               busy;
    bit               running;
    bit               stopping;
    dispatch_status_t status_due [DUE_DEPTH];
    int               due_wr;
    int               due_rd;
    int               errors;

    function void push_ready(logic [IdW-1:0] id);
      if (fill < NUM_IDS) begin
        ready_ids[(head + fill) % NUM_IDS] = id;
        fill++;
      end
    endfunction

    // number of status words waiting to be delivered
    function int due_count();
      return due_wr - due_rd;
    endfunction

    function void add_due(dispatch_status_t s);
      if (due_count() >= DUE_DEPTH) begin
        $error("status store overflow");
        errors++;
      end else begin
        status_due[due_wr % DUE_DEPTH] = s;
        due_wr++;
      end
    endfunction

    function dispatch_status_t take_due();
      dispatch_status_t s;
      s = status_due[due_rd % DUE_DEPTH];
      due_rd++;
      return s;
    endfunction

    // apply one accepted event word and queue the status it should produce
    function void note_event(logic [KindW-1:0] k, logic [IdW-1:0] id);
      dispatch_status_t s;
      bit id_ok;
      bit clear;
      s = '0;
      id_ok = int'(id) < NUM_IDS;
      case (k)
        EV_START: begin
          if (!running) begin
            stopping = 1'b0;
            running = 1'b1;
          end
        end
        EV_STOP: begin
          if (running || stopping) begin
            stopping = 1'b1;
            running = 1'b0;
            for (int i = 0; i < NUM_IDS; i++) pend[i] = 1'b0;
          end
        end
        EV_ENQUEUE: begin
          if (running && !stopping && id_ok) begin
            s.accepted = 1'b1;
            if (inflight[id]) begin
              pend[id] = 1'b1;
            end else if (!pend[id]) begin
              inflight[id] = 1'b1;
              if (busy < NUM_IDS) busy++;
              push_ready(id);
            end
          end
        end
        EV_TAKE: begin
          if (fill > 0) begin
            s.take_valid = 1'b1;
            s.take_id = ready_ids[head];
            head = (head + 1) % NUM_IDS;
            fill--;
          end
        end
        EV_COMPLETE: begin
          if (id_ok) begin
            // a pending id goes back on the ready fifo once while running
            if (pend[id] && running && !stopping) begin
              pend[id] = 1'b0;
              push_ready(id);
            end else begin
              pend[id] = 1'b0;
              inflight[id] = 1'b0;
              if (busy > 0) busy--;
            end
          end
        end
        default: ;
      endcase
      // drain finishes once nothing is in flight and the fifo is empty
      if (stopping && busy == 0 && fill == 0) begin
        stopping = 1'b0;
        for (int i = 0; i < NUM_IDS; i++) begin
          inflight[i] = 1'b0;
          pend[i] = 1'b0;
        end
      end
      clear = (busy == 0) && (fill == 0);
      for (int i = 0; i < NUM_IDS; i++)
        if (inflight[i] || pend[i]) clear = 1'b0;
      s.id_in_flight = id_ok && inflight[id];
      s.busy_count = CntW'(busy);
      s.idle = clear;
      s.is_running = running;
      s.draining = stopping;
      add_due(s);
    endfunction

    function void compare_field(string name, logic [CntW-1:0] want, logic [CntW-1:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        errors++;
      end
    endfunction

    // compare a delivered status word with the oldest one due
    function void check_status(dispatch_status_t got);
      dispatch_status_t want;
      if (due_count() == 0) begin
        $error("status word with none due");
        errors++;
        return;
      end
      want = take_due();
      compare_field("accepted", CntW'(want.accepted), CntW'(got.accepted));
      compare_field("take_valid", CntW'(want.take_valid), CntW'(got.take_valid));
      compare_field("take_id", CntW'(want.take_id), CntW'(got.take_id));
      compare_field("id_in_flight", CntW'(want.id_in_flight), CntW'(got.id_in_flight));
      compare_field("busy_count", want.busy_count, got.busy_count);
      compare_field("idle", CntW'(want.idle), CntW'(got.idle));
      compare_field("is_running", CntW'(want.is_running), CntW'(got.is_running));
      compare_field("draining", CntW'(want.draining), CntW'(got.draining));
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst;
  logic            in_valid;
  logic            in_stall;
  logic [KindW-1:0] kind;
  logic [IdW-1:0]  slot_id;
  logic            out_valid;
  logic            out_stall;
  logic            accepted;
  logic            take_valid;
  logic [IdW-1:0]  take_id;
  logic            id_in_flight;
  logic [CntW-1:0] busy_count;
  logic            idle;
  logic            is_running;
  logic            draining;

  dispatch_scoreboard sb;
  int idle_pct;
  int stall_pct;
  int quiet_cycles = 0;

  coalescing_job_dispatcher_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .slot_id      (slot_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .take_valid   (take_valid),
    .take_id      (take_id),
    .id_in_flight (id_in_flight),
    .busy_count   (busy_count),
    .idle         (idle),
    .is_running   (is_running),
    .draining     (draining)
  );

  always #2 clk = ~clk;

  // watchdog on cycles where neither channel moves a word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("coalescing_job_dispatcher_unit test failed");
      $finish;
    end
  end

  // present one event word, with random gaps, and hold it until taken
  task automatic send_word(input logic [KindW-1:0] k, input logic [IdW-1:0] id);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    slot_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_event(k, id);
  endtask

  // result side: random stall, check every word taken
  task automatic collect_status();
    forever begin
      out_stall <= ($urandom_range(99) < stall_pct);
      @(posedge clk);
      if (out_valid && !out_stall)
        sb.check_status({accepted, take_valid, take_id, id_in_flight,
                         busy_count, idle, is_running, draining});
    end
  endtask

  // extremes, coalescing, drain and the ignored cases
  task automatic run_directed();
    send_word(EV_ENQUEUE, 6'd17);
    send_word(EV_TAKE, 6'd0);
    send_word(EV_COMPLETE, 6'd9);
    send_word(EV_STOP, 6'd0);
    send_word(EV_SPARE_HI, 6'd63);
    send_word(EV_START, 6'd0);
    send_word(EV_START, 6'd0);
    send_word(EV_ENQUEUE, 6'd0);
    send_word(EV_ENQUEUE, 6'd63);
    send_word(EV_ENQUEUE, 6'd0);
    send_word(EV_ENQUEUE, 6'd0);
    send_word(EV_TAKE, 6'd63);
    send_word(EV_TAKE, 6'd0);
    send_word(EV_TAKE, 6'd0);
    send_word(EV_COMPLETE, 6'd0);
    send_word(EV_STOP, 6'd0);
    send_word(EV_ENQUEUE, 6'd42);
    send_word(EV_START, 6'd0);
    send_word(EV_STOP, 6'd0);
    send_word(EV_TAKE, 6'd0);
    send_word(EV_COMPLETE, 6'd0);
    send_word(EV_COMPLETE, 6'd63);
    send_word(EV_SPARE_LO, 6'd21);
    send_word(EV_SPARE_MID, 6'd42);
  endtask

  // empty everything, then fill the ready fifo and push against a full one
  task automatic fill_ready_fifo();
    for (int i = 0; i < NUM_IDS; i++) send_word(EV_TAKE, 6'(i));
    for (int i = 0; i < NUM_IDS; i++) send_word(EV_COMPLETE, 6'(i));
    send_word(EV_START, 6'd0);
    for (int i = 0; i < NUM_IDS; i++) send_word(EV_ENQUEUE, 6'(NUM_IDS - 1 - i));
    for (int i = 0; i < 4; i++) send_word(EV_ENQUEUE, 6'(i * 20));
    for (int i = 0; i < 4; i++) send_word(EV_COMPLETE, 6'(i * 20));
    for (int i = 0; i < NUM_IDS; i++) send_word(EV_TAKE, 6'd0);
  endtask

  // mostly a small set of ids so that coalescing happens often
  function automatic logic [IdW-1:0] pick_id();
    if ($urandom_range(99) < 70) return IdW'($urandom_range(7));
    return IdW'($urandom_range(NUM_IDS - 1));
  endfunction

  // prefer an id that is in flight, as a worker would complete
  function automatic logic [IdW-1:0] busy_id();
    logic [IdW-1:0] id;
    for (int t = 0; t < 8; t++) begin
      id = pick_id();
      if (sb.inflight[id]) return id;
    end
    return pick_id();
  endfunction

  task automatic run_random(input int n);
    int pick;
    logic [KindW-1:0] k;
    logic [IdW-1:0] id;
    for (int j = 0; j < n; j++) begin
      pick = $urandom_range(99);
      id = pick_id();
      if (!sb.running && $urandom_range(3) == 0) begin
        k = EV_START;
      end else if (pick < 4) begin
        k = EV_START;
      end else if (pick < 7) begin
        k = EV_STOP;
      end else if (pick < 42) begin
        k = EV_ENQUEUE;
      end else if (pick < 68) begin
        k = EV_TAKE;
      end else if (pick < 96) begin
        k = EV_COMPLETE;
        id = busy_id();
      end else begin
        k = KindW'($urandom_range(7, 5));
      end
      send_word(k, id);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    kind = '0;
    slot_id = '0;
    out_stall = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    fork
      collect_status();
    join_none
    run_directed();
    // phases: no idling, idle sender, stalling receiver, both
    fill_ready_fifo();
    run_random(140);
    idle_pct = 73;
    run_random(140);
    idle_pct = 0;
    stall_pct = 73;
    run_random(140);
    idle_pct = 33;
    stall_pct = 33;
    run_random(140);
    in_valid <= 1'b0;
    while (sb.due_count() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("coalescing_job_dispatcher_unit test passed");
    end else begin
      $display("coalescing_job_dispatcher_unit test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/cjd_pkg.sv
hw/rtl/coalescing_job_dispatcher_unit.sv
hw/rtl/cjd_checker.sv
tb/tb_coalescing_job_dispatcher_unit.sv
